>>> rtl/pbb_pkg.sv
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared types and constants for the page buffer bitmap blitter.
// ----------------------------------------------------------------------------
package pbb_pkg;

    localparam int BUF_WIDTH   = 128;
    localparam int BUF_HEIGHT  = 64;
    localparam int FRAME_PAGES = (BUF_HEIGHT + 7) / 8;
    localparam int COL_GROUPS  = (BUF_WIDTH + 7) / 8;
    localparam int STORE_DEPTH = FRAME_PAGES * COL_GROUPS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W       = $clog2(BUF_WIDTH);
    localparam int PAGE_W      = (FRAME_PAGES > 1) ? $clog2(FRAME_PAGES) : 1;
    localparam int GROUP_W     = (COL_GROUPS > 1) ? $clog2(COL_GROUPS) : 1;
    localparam int LANES       = 8;
    localparam int BANKS       = 8;

    localparam logic [8:0] ROW_MAX = 9'd511;

    // configuration register indexes
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_WIN_X      = 3'd2;
    localparam logic [2:0] REG_WIN_Y      = 3'd3;
    localparam logic [2:0] REG_WIN_W      = 3'd4;
    localparam logic [2:0] REG_WIN_H      = 3'd5;
    localparam logic [2:0] REG_DEST_X     = 3'd6;
    localparam logic [2:0] REG_DEST_Y     = 3'd7;

    localparam logic ACT_PIXELS = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel_byte;
        logic       first_of_bitmap;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] pixels_written;
    } result_t;

    // one pixel after clipping against window and frame columns
    typedef struct packed {
        logic             en;
        logic             pix;
        logic [COL_W-1:0] col;
    } lane_t;

    // destination row of the current source byte
    typedef struct packed {
        logic              ok;
        logic [2:0]        bank;
        logic [PAGE_W-1:0] page;
    } row_t;

    // write to one column bank
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } bank_wr_t;

endpackage

>>> rtl/pbb_ram.sv
// ----------------------------------------------------------------------------
// pbb_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module pbb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pbb_lane.sv
// ----------------------------------------------------------------------------
// pbb_lane
// One pixel of a source byte: window clip, translation, frame column clip.
// ----------------------------------------------------------------------------
module pbb_lane (
    input  logic                  [2:0] lane_idx,
    input  logic                  [4:0] col,
    input  logic                  [7:0] pixel_byte,
    input  logic                  [7:0] win_x,
    input  logic                  [8:0] win_w,
    input  logic                  [8:0] dest_x,
    output pbb_pkg::lane_t              lane
);

    logic [7:0]         px;
    logic               in_win;
    logic signed [10:0] dx;
    logic               dx_ok;

    always_comb
    begin
        px     = {col, lane_idx};
        in_win = ({2'b00, px} >= {2'b00, win_x}) &&
                 ({2'b00, px} < ({2'b00, win_x} + {1'b0, win_w}));
        dx     = $signed({{2{dest_x[8]}}, dest_x}) + $signed({3'b000, px})
                 - $signed({3'b000, win_x});
        dx_ok  = !dx[10] && (dx[9:0] < 10'(pbb_pkg::BUF_WIDTH));

        lane.en  = in_win && dx_ok;
        lane.pix = pixel_byte[3'd7 - lane_idx];
        lane.col = dx[pbb_pkg::COL_W-1:0];
    end

endmodule

>>> rtl/pbb_merge.sv
// ----------------------------------------------------------------------------
// pbb_merge
// Routes lane pixels onto the eight column banks and counts written pixels.
// ----------------------------------------------------------------------------
module pbb_merge (
    input  pbb_pkg::lane_t   lanes [pbb_pkg::LANES],
    input  pbb_pkg::row_t    row,
    input  logic             commit,
    output pbb_pkg::bank_wr_t bank_wr [pbb_pkg::BANKS],
    output logic [2:0]       row_bank,
    output logic [3:0]       count
);

    logic [pbb_pkg::ADDR_W-1:0] page_base;

    always_comb
    begin
        page_base = pbb_pkg::ADDR_W'(pbb_pkg::ADDR_W'(row.page) *
                                     pbb_pkg::ADDR_W'(pbb_pkg::COL_GROUPS));
        row_bank  = row.bank;
        count     = 4'd0;
        for (int b = 0; b < pbb_pkg::LANES; b++)
        begin
            count = count + {3'b000, lanes[b].en & row.ok};
        end

        // consecutive destination columns: at most one lane per bank
        for (int k = 0; k < pbb_pkg::BANKS; k++)
        begin
            bank_wr[k] = '0;
            for (int b = 0; b < pbb_pkg::LANES; b++)
            begin
                if (lanes[b].en && (lanes[b].col[2:0] == 3'(k)))
                begin
                    bank_wr[k].we   = row.ok && commit;
                    bank_wr[k].addr = page_base + pbb_pkg::ADDR_W'(
                                      pbb_pkg::GROUP_W'(lanes[b].col >> 3));
                    bank_wr[k].data = lanes[b].pix;
                end
            end
        end
    end

endmodule

>>> rtl/pbb_store.sv
// ----------------------------------------------------------------------------
// pbb_store
// Frame store as an 8 x 8 grid of one-bit banks (row and column mod 8),
// with the clearing sweep after reset.
// ----------------------------------------------------------------------------
module pbb_store (
    input  logic              clk,
    input  logic              rst_n,
    input  pbb_pkg::bank_wr_t bank_wr [pbb_pkg::BANKS],
    input  logic        [2:0] row_bank,
    input  logic              rd_en,
    input  logic        [2:0] rd_page,
    input  logic        [6:0] rd_column,
    output logic        [7:0] rd_data,
    output logic              busy
);

    logic                       clearing_reg;
    logic [pbb_pkg::ADDR_W-1:0] clr_addr_reg;
    logic [pbb_pkg::ADDR_W-1:0] rd_addr;
    logic                       rd_ok;
    logic                       rd_ok_reg;
    logic [2:0]                 rd_bank_reg;
    logic [7:0]                 bank_rdata [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == pbb_pkg::ADDR_W'(pbb_pkg::STORE_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        rd_ok   = (int'(rd_page) < pbb_pkg::FRAME_PAGES) &&
                  (int'(rd_column) < pbb_pkg::BUF_WIDTH);
        rd_addr = pbb_pkg::ADDR_W'(pbb_pkg::ADDR_W'(rd_page) *
                                   pbb_pkg::ADDR_W'(pbb_pkg::COL_GROUPS))
                  + pbb_pkg::ADDR_W'(rd_column >> 3);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_ok_reg   <= rd_ok;
            rd_bank_reg <= rd_column[2:0];
        end
    end

    for (genvar r = 0; r < 8; r++)
    begin : g_row
        for (genvar k = 0; k < pbb_pkg::BANKS; k++)
        begin : g_col
            logic                       we;
            logic [pbb_pkg::ADDR_W-1:0] waddr;
            logic                       wdata;

            always_comb
            begin
                we    = clearing_reg || (bank_wr[k].we && (row_bank == 3'(r)));
                waddr = clearing_reg ? clr_addr_reg : bank_wr[k].addr;
                wdata = clearing_reg ? 1'b0 : bank_wr[k].data;
            end

            pbb_ram #(
                .WIDTH (1),
                .DEPTH (pbb_pkg::STORE_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (we),
                .waddr (waddr),
                .wdata (wdata),
                .re    (rd_en),
                .raddr (rd_addr),
                .rdata (bank_rdata[r][k])
            );
        end

        assign rd_data[r] = rd_ok_reg & bank_rdata[r][rd_bank_reg];
    end

    assign busy = clearing_reg;

endmodule

>>> rtl/page_buffer_bitmap_blitter.sv
// ----------------------------------------------------------------------------
// page_buffer_bitmap_blitter
// Clipped 1-bpp bitmap copy into a page-organized frame store.
// ----------------------------------------------------------------------------
// Takes one word per clock while item_stall is low and returns one result word
// per input word. A source word's eight pixels are clipped in eight parallel
// lanes, registered in stage 2 and written together into an 8 x 8 grid of
// one-bit banks (frame row mod 8 by frame column mod 8), so every pixel has a
// write port of its own and a frame read fetches all eight rows of a column at
// once. After reset the store is swept to zero, one address of every bank per
// cycle, over FRAME_PAGES * ceil(BUF_WIDTH / 8) addresses (128 with the default
// 128 x 64 frame); item_stall stays high during the sweep. Configuration may
// be written at any time but should change only while no word is in flight.
module page_buffer_bitmap_blitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_en,
    input  logic       [2:0] cfg_index,
    input  logic       [8:0] cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  pbb_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pbb_pkg::result_t result
);

    // configuration
    logic [5:0] src_width_reg;
    logic [8:0] src_height_reg;
    logic [7:0] win_x_reg;
    logic [7:0] win_y_reg;
    logic [8:0] win_w_reg;
    logic [8:0] win_h_reg;
    logic [8:0] dest_x_reg;
    logic [8:0] dest_y_reg;

    // source position
    logic [8:0] row_reg;
    logic [4:0] col_reg;
    logic [8:0] cur_row;
    logic [4:0] cur_col;
    logic [5:0] col_inc;
    logic [8:0] row_next;
    logic [4:0] col_next;
    logic [5:0] width_eff;

    // pipeline
    logic       v1_reg, v2_reg, v3_reg;
    logic       act1_reg, act2_reg, act3_reg;
    logic [7:0] byte1_reg;
    logic [8:0] row1_reg;
    logic [4:0] col1_reg;
    logic [2:0] page1_reg, page2_reg;
    logic [6:0] column1_reg, column2_reg;
    logic [3:0] count3_reg;
    pbb_pkg::lane_t lanes_next [pbb_pkg::LANES];
    pbb_pkg::lane_t lanes2_reg [pbb_pkg::LANES];
    pbb_pkg::row_t  row_next_info;
    pbb_pkg::row_t  row2_reg;

    logic rdy1, rdy2, rdy3;
    logic acc_in, mv12, mv23;
    logic busy;

    logic signed [10:0] dy;
    logic               row_in_win;
    logic               dy_ok;

    pbb_pkg::bank_wr_t bank_wr [pbb_pkg::BANKS];
    logic [2:0]        row_bank;
    logic [3:0]        count;
    logic [7:0]        rd_data;
    logic [pbb_pkg::BANKS-1:0] bank_we;

    always_comb
    begin
        rdy3       = !v3_reg || !result_stall;
        rdy2       = !v2_reg || rdy3;
        rdy1       = !v1_reg || rdy2;
        item_stall = busy || !rdy1;
        acc_in     = item_valid && !item_stall;
        mv12       = v1_reg && rdy2;
        mv23       = v2_reg && rdy3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 6'd1;
            src_height_reg <= 9'd1;
            win_x_reg      <= '0;
            win_y_reg      <= '0;
            win_w_reg      <= '0;
            win_h_reg      <= '0;
            dest_x_reg     <= '0;
            dest_y_reg     <= '0;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                pbb_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[5:0];
                pbb_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                pbb_pkg::REG_WIN_X:      win_x_reg      <= cfg_data[7:0];
                pbb_pkg::REG_WIN_Y:      win_y_reg      <= cfg_data[7:0];
                pbb_pkg::REG_WIN_W:      win_w_reg      <= cfg_data;
                pbb_pkg::REG_WIN_H:      win_h_reg      <= cfg_data;
                pbb_pkg::REG_DEST_X:     dest_x_reg     <= cfg_data;
                pbb_pkg::REG_DEST_Y:     dest_y_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // position counter: row-major byte position in the source bitmap
    always_comb
    begin
        if (src_width_reg == 6'd0)
        begin
            width_eff = 6'd1;
        end
        else if (src_width_reg > 6'd32)
        begin
            width_eff = 6'd32;
        end
        else
        begin
            width_eff = src_width_reg;
        end

        cur_row = item.first_of_bitmap ? 9'd0 : row_reg;
        cur_col = item.first_of_bitmap ? 5'd0 : col_reg;
        col_inc = {1'b0, cur_col} + 6'd1;
        if (col_inc >= width_eff)
        begin
            col_next = 5'd0;
            row_next = (cur_row == pbb_pkg::ROW_MAX) ? cur_row : cur_row + 9'd1;
        end
        else
        begin
            col_next = col_inc[4:0];
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (acc_in && (item.action == pbb_pkg::ACT_PIXELS))
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (acc_in)
            begin
                v1_reg <= 1'b1;
            end
            else if (mv12)
            begin
                v1_reg <= 1'b0;
            end
            if (mv12)
            begin
                v2_reg <= 1'b1;
            end
            else if (mv23)
            begin
                v2_reg <= 1'b0;
            end
            if (mv23)
            begin
                v3_reg <= 1'b1;
            end
            else if (rdy3)
            begin
                v3_reg <= 1'b0;
            end
        end
    end

    // stage 1: accepted word with its source position
    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            act1_reg    <= item.action;
            byte1_reg   <= item.pixel_byte;
            row1_reg    <= cur_row;
            col1_reg    <= cur_col;
            page1_reg   <= item.read_page;
            column1_reg <= item.read_column;
        end
    end

    // row clip and destination row
    always_comb
    begin
        dy         = $signed({{2{dest_y_reg[8]}}, dest_y_reg})
                     + $signed({2'b00, row1_reg}) - $signed({3'b000, win_y_reg});
        row_in_win = ({1'b0, row1_reg} >= {2'b00, win_y_reg}) &&
                     ({1'b0, row1_reg} < ({2'b00, win_y_reg} + {1'b0, win_h_reg}));
        dy_ok      = !dy[10] && (dy[9:0] < 10'(pbb_pkg::BUF_HEIGHT));

        row_next_info.ok   = (act1_reg == pbb_pkg::ACT_PIXELS) &&
                             (row1_reg < src_height_reg) &&
                             ({1'b0, col1_reg} < width_eff) &&
                             row_in_win && dy_ok;
        row_next_info.bank = dy[2:0];
        row_next_info.page = pbb_pkg::PAGE_W'(dy[9:3]);
    end

    for (genvar b = 0; b < pbb_pkg::LANES; b++)
    begin : g_lane
        pbb_lane u_lane (
            .lane_idx   (3'(b)),
            .col        (col1_reg),
            .pixel_byte (byte1_reg),
            .win_x      (win_x_reg),
            .win_w      (win_w_reg),
            .dest_x     (dest_x_reg),
            .lane       (lanes_next[b])
        );
    end

    // stage 2: lane results
    always_ff @(posedge clk)
    begin
        if (mv12)
        begin
            act2_reg    <= act1_reg;
            lanes2_reg  <= lanes_next;
            row2_reg    <= row_next_info;
            page2_reg   <= page1_reg;
            column2_reg <= column1_reg;
        end
    end

    pbb_merge u_merge (
        .lanes    (lanes2_reg),
        .row      (row2_reg),
        .commit   (mv23),
        .bank_wr  (bank_wr),
        .row_bank (row_bank),
        .count    (count)
    );

    pbb_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .bank_wr   (bank_wr),
        .row_bank  (row_bank),
        .rd_en     (mv23 && (act2_reg == pbb_pkg::ACT_READ)),
        .rd_page   (page2_reg),
        .rd_column (column2_reg),
        .rd_data   (rd_data),
        .busy      (busy)
    );

    // stage 3: result word; read data sits in the bank read registers
    always_ff @(posedge clk)
    begin
        if (mv23)
        begin
            act3_reg   <= act2_reg;
            count3_reg <= count;
        end
    end

    always_comb
    begin
        result_valid          = v3_reg;
        result.read_data      = (act3_reg == pbb_pkg::ACT_READ) ? rd_data : 8'h00;
        result.pixels_written = count3_reg;
        for (int k = 0; k < pbb_pkg::BANKS; k++)
        begin
            bank_we[k] = bank_wr[k].we;
        end
    end

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("pipeline holds a word during the clearing sweep");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        mv23 |-> ($countones(bank_we) == int'(count)))
        else $error("bank writes disagree with pixel count");

    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mv23 && (act2_reg == pbb_pkg::ACT_READ)) |-> (bank_we == '0))
        else $error("frame read word issued bank writes");

    a_read_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (act3_reg == pbb_pkg::ACT_READ)) |-> (count3_reg == 4'd0))
        else $error("frame read word reports written pixels");

endmodule

>>> dv/blit_checker.sv
// ----------------------------------------------------------------------------
// blit_checker
// Watches the register port and both word channels of the bitmap blitter.
// It keeps its own frame image, source position and register copies, works
// out the result of every accepted input word, and compares each returned
// word field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module blit_checker
    import pbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_en,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       item_valid,
    input  logic       item_stall,
    input  item_t      item,
    input  logic       result_valid,
    input  logic       result_stall,
    input  result_t    result,
    output int         mismatches,
    output int         pending
);

    localparam int FRAME_BYTES = FRAME_PAGES * BUF_WIDTH;
    localparam int ROW_LIMIT   = 511;

    logic [7:0] frame_img [0:FRAME_BYTES-1];
    int         row_pos;
    int         col_pos;

    logic [5:0]        src_w_reg;
    logic [8:0]        src_h_reg;
    logic [7:0]        win_x_reg;
    logic [7:0]        win_y_reg;
    logic [8:0]        win_w_reg;
    logic [8:0]        win_h_reg;
    logic signed [8:0] dest_x_reg;
    logic signed [8:0] dest_y_reg;

    result_t result_due [$];

    // works out the result of one word; a pixel word also updates the frame image and source position
    function automatic result_t blit_predict(input item_t w);
        result_t r;
        int      width;
        int      wx;
        int      wy;
        int      ww;
        int      wh;
        int      dy;
        int      px;
        int      dx;
        int      base;
        int      count;
        logic [7:0] row_bit;
        r = '0;
        if (w.action == ACT_READ)
        begin
            if (int'(w.read_page) < FRAME_PAGES && int'(w.read_column) < BUF_WIDTH)
                r.read_data = frame_img[int'(w.read_page) * BUF_WIDTH + int'(w.read_column)];
            return r;
        end
        if (w.first_of_bitmap)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        width = int'(src_w_reg);
        if (width < 1)
            width = 1;
        if (width > 32)
            width = 32;
        count = 0;
        wx = int'(win_x_reg);
        wy = int'(win_y_reg);
        ww = int'(win_w_reg);
        wh = int'(win_h_reg);
        if (row_pos < int'(src_h_reg) && col_pos < width
            && row_pos >= wy && row_pos < wy + wh)
        begin
            dy = int'(dest_y_reg) + (row_pos - wy);
            if (dy >= 0 && dy < BUF_HEIGHT)
            begin
                row_bit = 8'(1 << (dy % 8));
                base    = (dy / 8) * BUF_WIDTH;
                for (int b = 0; b < 8; b++)
                begin
                    px = col_pos * 8 + b;
                    dx = int'(dest_x_reg) + (px - wx);
                    if (px >= wx && px < wx + ww && dx >= 0 && dx < BUF_WIDTH)
                    begin
                        if (w.pixel_byte[7-b])
                            frame_img[base + dx] = frame_img[base + dx] | row_bit;
                        else
                            frame_img[base + dx] = frame_img[base + dx] & ~row_bit;
                        count++;
                    end
                end
            end
        end
        col_pos++;
        if (col_pos >= width)
        begin
            col_pos = 0;
            if (row_pos < ROW_LIMIT)
                row_pos++;
        end
        r.pixels_written = 4'(count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_img[i] = '0;
            row_pos    = 0;
            col_pos    = 0;
            src_w_reg  = 6'd1;
            src_h_reg  = 9'd1;
            win_x_reg  = '0;
            win_y_reg  = '0;
            win_w_reg  = '0;
            win_h_reg  = '0;
            dest_x_reg = '0;
            dest_y_reg = '0;
            result_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_en)
            begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_w_reg  = cfg_data[5:0];
                    REG_SRC_HEIGHT: src_h_reg  = cfg_data;
                    REG_WIN_X:      win_x_reg  = cfg_data[7:0];
                    REG_WIN_Y:      win_y_reg  = cfg_data[7:0];
                    REG_WIN_W:      win_w_reg  = cfg_data;
                    REG_WIN_H:      win_h_reg  = cfg_data;
                    REG_DEST_X:     dest_x_reg = cfg_data;
                    REG_DEST_Y:     dest_y_reg = cfg_data;
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                result_due.push_back(blit_predict(item));
            if (result_valid && !result_stall)
            begin
                if (result_due.size() == 0)
                begin
                    $error("result word with nothing outstanding: %0h", result);
                    mismatches++;
                end
                else
                begin
                    want = result_due.pop_front();
                    if (result.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0h, got %0h",
                               want.read_data, result.read_data);
                        mismatches++;
                    end
                    if (result.pixels_written !== want.pixels_written)
                    begin
                        $error("pixels_written: expected %0d, got %0d",
                               want.pixels_written, result.pixels_written);
                        mismatches++;
                    end
                end
            end
        end
        pending = result_due.size();
    end

endmodule

>>> dv/tb_page_buffer_bitmap_blitter.sv
// ----------------------------------------------------------------------------
// tb_page_buffer_bitmap_blitter
// Stimulus and verdict for the page buffer bitmap blitter. Runs directed
// blits over the clipping corners, then randomized window/destination
// settings with bitmap streams, frame reads and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_page_buffer_bitmap_blitter;

    import pbb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1850;
    localparam int HOLD_CYCLES = 300;

    logic       clk;
    logic       rst_n;
    logic       cfg_en;
    logic [2:0] cfg_index;
    logic [8:0] cfg_data;
    logic       item_valid;
    logic       item_stall;
    item_t      item;
    logic       result_valid;
    logic       result_stall;
    result_t    result;

    int mismatches;
    int pending;
    int cycles = 0;
    int n_words;
    int n_reads;
    int n_settings;
    int burst_left;
    int hold_left;
    int stall_mode;
    int mode_left;
    int pattern_ctr;
    int hold_reqs;
    int hold_seen;

    page_buffer_bitmap_blitter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    blit_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin
        result_stall <= 1'b0;
        hold_left   = 0;
        hold_seen   = 0;
        stall_mode  = 0;
        mode_left   = 0;
        pattern_ctr = 0;
        forever
        begin
            @(posedge clk);
            pattern_ctr++;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= ((pattern_ctr % 5) < 2);
                endcase
            end
        end
    end

    task automatic send_word(input item_t w);
        logic stalled;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= w;
        // stall settles after the edge; sample it mid-cycle
        do
        begin
            @(negedge clk);
            stalled = item_stall;
            @(posedge clk);
        end
        while (stalled);
        n_words++;
    endtask

    task automatic pix_word(input logic [7:0] pixels, input logic first);
        item_t w;
        w.action          = ACT_PIXELS;
        w.pixel_byte      = pixels;
        w.first_of_bitmap = first;
        w.read_page       = 3'($urandom);
        w.read_column     = 7'($urandom);
        send_word(w);
    endtask

    task automatic read_word(input int page, input int col);
        item_t w;
        w.action          = ACT_READ;
        w.pixel_byte      = 8'($urandom);
        w.first_of_bitmap = 1'($urandom);
        w.read_page       = 3'(page);
        w.read_column     = 7'(col);
        send_word(w);
        n_reads++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int sw, input int sh, input int wx, input int wy,
                                input int ww, input int wh, input int dxv, input int dyv);
        drain();
        write_reg(REG_SRC_WIDTH,  9'(sw));
        write_reg(REG_SRC_HEIGHT, 9'(sh));
        write_reg(REG_WIN_X,      9'(wx));
        write_reg(REG_WIN_Y,      9'(wy));
        write_reg(REG_WIN_W,      9'(ww));
        write_reg(REG_WIN_H,      9'(wh));
        write_reg(REG_DEST_X,     9'(dxv));
        write_reg(REG_DEST_Y,     9'(dyv));
        cfg_en <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        int sw;
        int eff;
        int sh;
        int wx;
        int wy;
        int ww;
        int wh;
        int dxv;
        int dyv;
        int n_bytes;
        int phase;
        int col;
        int page;
        rst_n      <= 1'b0;
        cfg_en     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        item_valid <= 1'b0;
        item       <= '0;
        n_words    = 0;
        n_reads    = 0;
        n_settings = 0;
        burst_left = 0;
        hold_reqs  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty window, nothing lands
        pix_word(8'hFF, 1'b1);
        pix_word(8'h00, 1'b0);
        read_word(0, 0);

        // two-byte rows, height 2: third row is past the bitmap
        set_geometry(2, 2, 0, 0, 16, 8, 0, 0);
        pix_word(8'hFF, 1'b1);
        pix_word(8'h80, 1'b0);
        pix_word(8'h01, 1'b0);
        pix_word(8'h55, 1'b0);
        pix_word(8'hFF, 1'b0);
        pix_word(8'hFF, 1'b0);
        read_word(0, 0);
        read_word(0, 8);
        read_word(0, 15);
        read_word(7, 127);

        // zero width acts as one byte; window clipped on top and left edges
        set_geometry(0, 256, 3, 0, 5, 256, -2, -1);
        pix_word(8'hFF, 1'b1);
        pix_word(8'hFF, 1'b0);
        pix_word(8'h1F, 1'b0);
        read_word(0, 0);
        read_word(0, 1);

        // oversize width clamps to 32; window lands on the bottom-right corner
        set_geometry(63, 1, 0, 0, 256, 1, 120, 63);
        pix_word(8'hA5, 1'b1);
        pix_word(8'hFF, 1'b0);
        read_word(7, 120);
        read_word(7, 127);

        // destination extremes put the whole window outside the frame
        set_geometry(1, 1, 255, 255, 256, 256, 255, -256);
        pix_word(8'hFF, 1'b1);
        read_word(7, 127);

        phase = 0;
        while (n_words < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0: sw = 0;
                1: sw = 32;
                2: sw = 63;
                default: sw = $urandom_range(1, 4);
            endcase
            eff = (sw < 1) ? 1 : (sw > 32) ? 32 : sw;
            sh = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 256 : 1)
                                             : $urandom_range(1, 10);
            wx = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, eff * 8 - 1);
            wy = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0: ww = 0;
                1: ww = 256;
                default: ww = $urandom_range(1, eff * 8);
            endcase
            case ($urandom_range(0, 9))
                0: wh = 0;
                1: wh = 256;
                default: wh = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 9))
                0: dxv = -256;
                1: dxv = 255;
                default: dxv = $urandom_range(0, 140) - 12;
            endcase
            case ($urandom_range(0, 9))
                0: dyv = -256;
                1: dyv = 255;
                default: dyv = $urandom_range(0, 76) - 12;
            endcase
            n_bytes = eff * (((sh > 10) ? 10 : sh) + 1);
            if (n_bytes > 120)
                n_bytes = 120;
            if ($urandom_range(0, 7) == 0)
                n_bytes = $urandom_range(1, n_bytes);
            // one long single-column stream runs the row count toward saturation,
            // with the receiver held off so the pipe backs up
            if (phase == 4)
            begin
                sw = 1;
                sh = 256;
                wx = 0;
                wy = 0;
                ww = 8;
                wh = 256;
                dxv = $urandom_range(0, 120);
                dyv = 0;
                n_bytes = 530;
            end
            set_geometry(sw, sh, wx, wy, ww, wh, dxv, dyv);
            if (phase == 4)
                hold_reqs++;
            for (int i = 0; i < n_bytes; i++)
            begin
                if ($urandom_range(0, 99) < 12)
                    read_word($urandom_range(0, 7), $urandom_range(0, 127));
                pix_word(8'($urandom), (i == 0) || ($urandom_range(0, 99) < 2));
            end
            for (int i = 0; i < 8; i++)
            begin
                col  = dxv + $urandom_range(0, 23);
                page = (dyv >= 0 && dyv < BUF_HEIGHT) ? dyv / 8 + $urandom_range(0, 1)
                                                       : $urandom_range(0, 7);
                if (col < 0 || col >= BUF_WIDTH)
                    col = $urandom_range(0, BUF_WIDTH - 1);
                if (page >= FRAME_PAGES)
                    page = FRAME_PAGES - 1;
                read_word(page, col);
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        $display("blit run: %0d words accepted, %0d of them frame reads", n_words, n_reads);
        $display("%0d register settings incl. clamped widths, empty windows, row saturation",
                 n_settings);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/pbb_pkg.sv
rtl/pbb_ram.sv
rtl/pbb_lane.sv
rtl/pbb_merge.sv
rtl/pbb_store.sv
rtl/page_buffer_bitmap_blitter.sv
dv/blit_checker.sv
dv/tb_page_buffer_bitmap_blitter.sv
